// File: hw/rtl/tccb_pkg.sv
// shared constants, types and helper functions of the text console cell buffer
package tccb_pkg;

  localparam int MAX_COLS  = 64;
  localparam int MAX_ROWS  = 32;
  localparam int TAB_WIDTH = 4;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int CELLS  = MAX_COLS * MAX_ROWS;

  localparam logic [7:0] SPACE_CHAR = 8'd32;
  localparam logic [7:0] CODE_LF    = 8'd10;
  localparam logic [7:0] CODE_CR    = 8'd13;
  localparam logic [7:0] CODE_TAB   = 8'd9;
  localparam logic [7:0] OOR_COLOR  = 8'd1;

  localparam logic [6:0] COLS_RESET  = 7'd40;
  localparam logic [5:0] ROWS_RESET  = 6'd25;
  localparam logic [7:0] COLOR_RESET = 8'd1;

  typedef enum logic [3:0] {
    ACT_PRINT,
    ACT_SET_CURSOR,
    ACT_MOVE_CURSOR,
    ACT_WRITE_CHAR,
    ACT_WRITE_COLOR,
    ACT_READ_CELL,
    ACT_CLEAR,
    ACT_SCROLL_UP,
    ACT_SCROLL_DOWN
  } action_t;

  typedef enum logic [1:0] {
    REG_COLUMNS,
    REG_ROWS,
    REG_COLOR
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SWEEP_NONE,
    SWEEP_FILL,
    SWEEP_SCROLL
  } sweep_t;

  typedef struct packed {
    logic              chr_en;
    logic              clr_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        chr;
    logic [7:0]        clr;
  } wr_req_t;

  typedef struct packed {
    wr_req_t           wr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              is_read;
    logic              rd_in_range;
    sweep_t            sweep;
    logic              scroll_up;
    logic [ROW_W-1:0]  scroll_lines;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
  } cmd_t;

  // a size of zero acts as one, anything above the maximum as the maximum
  function automatic logic [COL_W:0] eff_cols(input logic [6:0] c);
    logic [COL_W:0] r;
    if (c == 7'd0) r = (COL_W+1)'(1);
    else if (c > 7'(MAX_COLS)) r = (COL_W+1)'(MAX_COLS);
    else r = (COL_W+1)'(c);
    return r;
  endfunction

  function automatic logic [ROW_W:0] eff_rows(input logic [5:0] c);
    logic [ROW_W:0] r;
    if (c == 6'd0) r = (ROW_W+1)'(1);
    else if (c > 6'(MAX_ROWS)) r = (ROW_W+1)'(MAX_ROWS);
    else r = (ROW_W+1)'(c);
    return r;
  endfunction

  function automatic logic [6:0] clamp_pos(input logic signed [9:0] v, input logic [6:0] hi);
    logic [6:0] r;
    if (v < 10'sd0) r = 7'd0;
    else if (v > $signed({3'b000, hi})) r = hi;
    else r = v[6:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/tccb_cell_ram.sv
// character and color cell memories, one write and one registered read port
module tccb_cell_ram
  import tccb_pkg::*;
(
  input  logic              clk,
  input  wr_req_t           wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_chr,
  output logic [7:0]        rd_clr
);

  logic [7:0] chr_mem [CELLS];
  logic [7:0] clr_mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr.chr_en) begin
      chr_mem[wr.addr] <= wr.chr;
    end
    if (wr.clr_en) begin
      clr_mem[wr.addr] <= wr.clr;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_chr <= chr_mem[rd_addr];
      rd_clr <= clr_mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/tccb_decode.sv
// action decoder: cursor update, single cell accesses and sweep requests
module tccb_decode
  import tccb_pkg::*;
(
  input  logic              [3:0]       action,
  input  logic              [7:0]       code,
  input  logic signed       [7:0]       col,
  input  logic signed       [7:0]       row,
  input  logic              [7:0]       color,
  input  logic              [5:0]       lines,
  input  logic              [COL_W-1:0] cur_col,
  input  logic              [ROW_W-1:0] cur_row,
  input  logic              [6:0]       cols_cfg,
  input  logic              [5:0]       rows_cfg,
  input  logic              [7:0]       cur_color,
  output cmd_t                          cmd
);

  logic [COL_W:0]   ec;
  logic [ROW_W:0]   er;
  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;
  logic             in_rng;
  logic             cur_in;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic             line_wrap;
  logic [7:0]       tab_stop;
  logic [COL_W-1:0] tab_col;
  logic signed [9:0] set_col;
  logic signed [9:0] set_row;
  logic signed [9:0] mv_col;
  logic signed [9:0] mv_row;
  logic [6:0]       cl_set_col;
  logic [6:0]       cl_set_row;
  logic [6:0]       cl_mv_col;
  logic [6:0]       cl_mv_row;
  logic [ADDR_W-1:0] in_addr;

  assign ec       = eff_cols(cols_cfg);
  assign er       = eff_rows(rows_cfg);
  assign last_col = COL_W'(ec - (COL_W+1)'(1));
  assign last_row = ROW_W'(er - (ROW_W+1)'(1));

  assign in_rng = ($unsigned(col) < 8'(ec)) && ($unsigned(row) < 8'(er));
  assign cur_in = ({1'b0, cur_col} < ec) && ({1'b0, cur_row} < er);
  assign in_addr = {row[ROW_W-1:0], col[COL_W-1:0]};

  assign col_inc   = {1'b0, cur_col} + (COL_W+1)'(1);
  assign row_inc   = {1'b0, cur_row} + (ROW_W+1)'(1);
  assign line_wrap = row_inc >= er;

  // next tab stop, held at the last column
  assign tab_stop = 8'(({2'b00, cur_col} / TAB_WIDTH + 1) * TAB_WIDTH);
  assign tab_col  = (tab_stop < 8'(last_col)) ? tab_stop[COL_W-1:0] : last_col;

  assign set_col = $signed({{2{col[7]}}, col});
  assign set_row = $signed({{2{row[7]}}, row});
  assign mv_col  = $signed({4'b0000, cur_col}) + set_col;
  assign mv_row  = $signed({5'b00000, cur_row}) + set_row;

  assign cl_set_col = clamp_pos(set_col, 7'(last_col));
  assign cl_set_row = clamp_pos(set_row, 7'(last_row));
  assign cl_mv_col  = clamp_pos(mv_col, 7'(last_col));
  assign cl_mv_row  = clamp_pos(mv_row, 7'(last_row));

  always_comb begin
    cmd         = '0;
    cmd.sweep   = SWEEP_NONE;
    cmd.cur_col = cur_col;
    cmd.cur_row = cur_row;
    unique case (action)
      ACT_PRINT: begin
        if (code == CODE_CR) begin
          cmd.cur_col = '0;
        end else if (code == CODE_TAB) begin
          cmd.cur_col = tab_col;
        end else begin
          if (code != CODE_LF) begin
            cmd.wr.chr_en = cur_in;
            cmd.wr.clr_en = cur_in;
            cmd.wr.addr   = {cur_row, cur_col};
            cmd.wr.chr    = code;
            cmd.wr.clr    = cur_color;
          end
          if ((code != CODE_LF) && (col_inc < ec)) begin
            cmd.cur_col = col_inc[COL_W-1:0];
          end else begin
            cmd.cur_col = '0;
            if (line_wrap) begin
              // bottom line: scroll up one row, a one-row screen clears instead
              cmd.cur_row      = last_row;
              cmd.sweep        = (er == (ROW_W+1)'(1)) ? SWEEP_FILL : SWEEP_SCROLL;
              cmd.scroll_up    = 1'b1;
              cmd.scroll_lines = ROW_W'(1);
            end else begin
              cmd.cur_row = row_inc[ROW_W-1:0];
            end
          end
        end
      end
      ACT_SET_CURSOR: begin
        cmd.cur_col = cl_set_col[COL_W-1:0];
        cmd.cur_row = cl_set_row[ROW_W-1:0];
      end
      ACT_MOVE_CURSOR: begin
        cmd.cur_col = cl_mv_col[COL_W-1:0];
        cmd.cur_row = cl_mv_row[ROW_W-1:0];
      end
      ACT_WRITE_CHAR: begin
        cmd.wr.chr_en = in_rng;
        cmd.wr.addr   = in_addr;
        cmd.wr.chr    = code;
      end
      ACT_WRITE_COLOR: begin
        cmd.wr.clr_en = in_rng;
        cmd.wr.addr   = in_addr;
        cmd.wr.clr    = color;
      end
      ACT_READ_CELL: begin
        cmd.is_read     = 1'b1;
        cmd.rd_in_range = in_rng;
        cmd.rd_en       = in_rng;
        cmd.rd_addr     = in_addr;
      end
      ACT_CLEAR: begin
        cmd.sweep   = SWEEP_FILL;
        cmd.cur_col = '0;
        cmd.cur_row = '0;
      end
      ACT_SCROLL_UP, ACT_SCROLL_DOWN: begin
        if ((lines == 6'd0) || (lines >= 6'(er))) begin
          cmd.sweep   = SWEEP_FILL;
          cmd.cur_col = '0;
          cmd.cur_row = '0;
        end else begin
          cmd.sweep        = SWEEP_SCROLL;
          cmd.scroll_up    = (action == ACT_SCROLL_UP);
          cmd.scroll_lines = lines[ROW_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/text_console_cell_buffer.sv
// Text console cell buffer: cell memories, sweep sequencer and result register.
// Cursor and single-cell write actions are taken at one item per cycle when the result register is free.
// Read cell goes through the registered memory read port and then the finish step.
// Clear, and a scroll of zero or at least the row count, sweep all 2048 cells.
// Scroll by N rows walks rows x columns cells one a cycle through the memory.
// After reset a clearing pass fills all 2048 cells; no item is taken until it ends.
module text_console_cell_buffer
  import tccb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [3:0]  s_tuser,   // action
  input  logic [39:0] s_tdata,   // code, col, row, color, lines
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // char_out, color_out, cursor_col, cursor_row
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_SCROLL,
    ST_FIN
  } state_t;

  state_t            state;
  logic [6:0]        cols_cfg;
  logic [5:0]        rows_cfg;
  logic [7:0]        cur_color;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ADDR_W-1:0] fill_cnt;
  logic [7:0]        fill_color;
  logic [ROW_W-1:0]  srow;
  logic [COL_W-1:0]  scol;
  logic              sc_up;
  logic [ROW_W-1:0]  sc_lines;
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_addr;
  logic              pend_copy;
  logic              res_read;
  logic              res_in;

  cmd_t              cmd;
  wr_req_t           wr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_chr;
  logic [7:0]        rd_clr;
  logic              accept;
  logic              slot_free;
  logic              direct;
  logic              res_load;
  logic [COL_W:0]    ec;
  logic [ROW_W:0]    er;
  logic [COL_W-1:0]  last_col;
  logic [ROW_W-1:0]  last_row;
  logic              sc_copy;
  logic [ROW_W-1:0]  src_row;
  logic              row_end;
  logic [7:0]        fin_chr;
  logic [7:0]        fin_clr;

  tccb_decode u_decode (
    .action    (s_tuser),
    .code      (s_tdata[7:0]),
    .col       (s_tdata[15:8]),
    .row       (s_tdata[23:16]),
    .color     (s_tdata[31:24]),
    .lines     (s_tdata[37:32]),
    .cur_col   (cur_col),
    .cur_row   (cur_row),
    .cols_cfg  (cols_cfg),
    .rows_cfg  (rows_cfg),
    .cur_color (cur_color),
    .cmd       (cmd)
  );

  tccb_cell_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_chr  (rd_chr),
    .rd_clr  (rd_clr)
  );

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign direct    = (cmd.sweep == SWEEP_NONE) && !cmd.is_read && slot_free;
  // result register loads straight from an accepted item or from the finish step
  assign res_load  = (accept && direct) || ((state == ST_FIN) && slot_free);

  assign ec       = eff_cols(cols_cfg);
  assign er       = eff_rows(rows_cfg);
  assign last_col = COL_W'(ec - (COL_W+1)'(1));
  assign last_row = ROW_W'(er - (ROW_W+1)'(1));

  // up: destination row takes row+n while that is on screen; down: row-n while row >= n
  assign sc_copy = sc_up ? (({1'b0, srow} + {1'b0, sc_lines}) < er) : (srow >= sc_lines);
  assign src_row = sc_up ? (srow + sc_lines) : (srow - sc_lines);
  assign row_end = sc_up ? (srow == last_row) : (srow == '0);

  always_comb begin
    wr = '0;
    if ((state == ST_INIT) || (state == ST_FILL)) begin
      wr.chr_en = 1'b1;
      wr.clr_en = 1'b1;
      wr.addr   = fill_cnt;
      wr.chr    = SPACE_CHAR;
      wr.clr    = fill_color;
    end else if (pend_valid) begin
      // copy write lands in the cycle after its source read
      wr.chr_en = 1'b1;
      wr.clr_en = 1'b1;
      wr.addr   = pend_addr;
      wr.chr    = pend_copy ? rd_chr : SPACE_CHAR;
      wr.clr    = pend_copy ? rd_clr : fill_color;
    end else if (accept) begin
      wr = cmd.wr;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if ((state == ST_SCROLL) && sc_copy) begin
      rd_en   = 1'b1;
      rd_addr = {src_row, scol};
    end else if (accept && cmd.rd_en) begin
      rd_en   = 1'b1;
      rd_addr = cmd.rd_addr;
    end
  end

  assign fin_chr = res_read ? (res_in ? rd_chr : SPACE_CHAR) : 8'd0;
  assign fin_clr = res_read ? (res_in ? rd_clr : OOR_COLOR) : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_cfg  <= COLS_RESET;
      rows_cfg  <= ROWS_RESET;
      cur_color <= COLOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COLUMNS: cols_cfg  <= cfg_data[6:0];
        REG_ROWS:    rows_cfg  <= cfg_data[5:0];
        REG_COLOR:   cur_color <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      fill_cnt   <= '0;
      fill_color <= COLOR_RESET;
      cur_col    <= '0;
      cur_row    <= '0;
      srow       <= '0;
      scol       <= '0;
      sc_up      <= 1'b0;
      sc_lines   <= '0;
      pend_valid <= 1'b0;
      res_read   <= 1'b0;
      res_in     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      pend_valid <= (state == ST_SCROLL);
      m_tvalid   <= res_load || (m_tvalid && !m_tready);
      unique case (state)
        ST_INIT: begin
          fill_cnt <= fill_cnt + ADDR_W'(1);
          if (fill_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cur_col    <= cmd.cur_col;
            cur_row    <= cmd.cur_row;
            res_read   <= cmd.is_read;
            res_in     <= cmd.rd_in_range;
            fill_color <= cur_color;
            sc_up      <= cmd.scroll_up;
            sc_lines   <= cmd.scroll_lines;
            scol       <= '0;
            srow       <= cmd.scroll_up ? '0 : last_row;
            fill_cnt   <= '0;
            case (cmd.sweep)
              SWEEP_FILL:   state <= ST_FILL;
              SWEEP_SCROLL: state <= ST_SCROLL;
              default: begin
                if (direct) begin
                  m_tdata <= {5'b00000, cmd.cur_row, cmd.cur_col, 8'd0, 8'd0};
                end else begin
                  state <= ST_FIN;
                end
              end
            endcase
          end
        end
        ST_FILL: begin
          fill_cnt <= fill_cnt + ADDR_W'(1);
          if (fill_cnt == '1) begin
            state <= ST_FIN;
          end
        end
        ST_SCROLL: begin
          pend_addr <= {srow, scol};
          pend_copy <= sc_copy;
          if (scol == last_col) begin
            scol <= '0;
            if (row_end) begin
              state <= ST_FIN;
            end else begin
              srow <= sc_up ? (srow + ROW_W'(1)) : (srow - ROW_W'(1));
            end
          end else begin
            scol <= scol + COL_W'(1);
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            m_tdata <= {5'b00000, cur_row, cur_col, fin_clr, fin_chr};
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_pend_from_scroll: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> $past(state) == ST_SCROLL)
    else $error("pending cell write without a scroll step before it");

  a_no_read_write_clash: assert property (@(posedge clk) disable iff (rst)
    (rd_en && pend_valid) |-> (rd_addr != pend_addr))
    else $error("scroll read hits the cell being written");

  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FIN) && slot_free) |=> (m_tvalid && (state == ST_IDLE)))
    else $error("finished item not moved into the result register");

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for the text console cell buffer: directed table, then random screen phases
`timescale 1ns / 1ps

module tb
  import tccb_pkg::*;
;

  localparam int CYCLE_LIMIT     = 5_000_000;
  localparam int SWEEP_DRAIN     = CELLS + 64;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TAIL_CYCLES     = 64;
  localparam int STEADY_PHASE    = 3;
  localparam int STRESS_PHASE    = 4;
  localparam int STRESS_ITEMS    = 40;
  localparam logic [3:0] ACT_UNUSED_LO = 4'(ACT_SCROLL_DOWN) + 4'd1;
  localparam logic [3:0] ACT_UNUSED_HI = 4'hf;

  typedef struct {
    logic [3:0]        act;
    logic [7:0]        code;
    logic signed [7:0] col;
    logic signed [7:0] row;
    logic [7:0]        color;
    logic [5:0]        lines;
  } console_item_t;

  typedef struct {
    logic [7:0] chr;
    logic [7:0] clr;
    logic [5:0] ccol;
    logic [4:0] crow;
  } cell_report_t;

  typedef struct {
    logic [3:0] act;
    logic [7:0] code;
    int         col;
    int         row;
    logic [7:0] color;
    logic [5:0] lines;
    bit         typed;
    logic [7:0] g_chr;
    logic [7:0] g_clr;
    int         g_col;
    int         g_row;
  } directed_row_t;

  typedef struct {
    logic [7:0] cols;
    logic [7:0] rows;
    logic [7:0] color;
    int         items;
  } screen_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [3:0]  s_tuser = '0;   // action
  logic [39:0] s_tdata = '0;   // code, col, row, color, lines
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // char_out, color_out, cursor_col, cursor_row
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  text_console_cell_buffer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the console
  logic [7:0] shadow_chr [CELLS];
  logic [7:0] shadow_clr [CELLS];
  int         cur_c;
  int         cur_r;
  logic [6:0] cols_reg;
  logic [5:0] rows_reg;
  logic [7:0] color_reg;

  cell_report_t awaited_cell_reports [$];
  int           mismatch_count = 0;
  int           reports_seen = 0;
  int           cycle_count = 0;
  bit           hold_off_req = 1'b0;
  bit           steady = 1'b0;

  directed_row_t directed_rows [25] = '{
    '{ACT_READ_CELL,   0,    0,    0,    0,   0, 1, SPACE_CHAR, OOR_COLOR, 0, 0},
    '{ACT_READ_CELL,   0,   -1,    0,    0,   0, 1, SPACE_CHAR, OOR_COLOR, 0, 0},
    '{ACT_READ_CELL,   0,  127,  127,    0,   0, 1, SPACE_CHAR, OOR_COLOR, 0, 0},
    '{ACT_READ_CELL,   0, -128, -128,    0,   0, 1, SPACE_CHAR, OOR_COLOR, 0, 0},
    '{ACT_PRINT,      65,    0,    0,    0,   0, 1, 0, 0, 1, 0},
    '{ACT_PRINT,     255,    0,    0,    0,   0, 1, 0, 0, 2, 0},
    '{ACT_PRINT,       0,    0,    0,    0,   0, 1, 0, 0, 3, 0},
    '{ACT_PRINT, CODE_TAB,   0,    0,    0,   0, 1, 0, 0, 4, 0},
    '{ACT_PRINT, CODE_CR,    0,    0,    0,   0, 1, 0, 0, 0, 0},
    '{ACT_PRINT, CODE_LF,    0,    0,    0,   0, 1, 0, 0, 0, 1},
    '{ACT_SET_CURSOR,  0,   38, -128,    0,   0, 1, 0, 0, 38, 0},
    // tab stop past the last column is capped there
    '{ACT_PRINT, CODE_TAB,   0,    0,    0,   0, 1, 0, 0, 39, 0},
    '{ACT_SET_CURSOR,  0,  127,  127,    0,   0, 1, 0, 0, 39, 24},
    // bottom right: wrap and scroll
    '{ACT_PRINT,      90,    0,    0,    0,   0, 0, 0, 0, 0, 0},
    '{ACT_MOVE_CURSOR, 0, -128, -128,    0,   0, 1, 0, 0, 0, 0},
    '{ACT_MOVE_CURSOR, 0,    3,    2,    0,   0, 0, 0, 0, 0, 0},
    '{ACT_WRITE_CHAR, 126,   2,    1,    0,   0, 0, 0, 0, 0, 0},
    '{ACT_WRITE_COLOR,  0,   2,    1,  255,   0, 0, 0, 0, 0, 0},
    '{ACT_WRITE_CHAR,  66,  40,    0,    0,   0, 0, 0, 0, 0, 0},
    '{ACT_READ_CELL,    0,   2,    1,    0,   0, 0, 0, 0, 0, 0},
    '{ACT_SCROLL_DOWN,  0,   0,    0,    0,   2, 0, 0, 0, 0, 0},
    '{ACT_SCROLL_UP,    0,   0,    0,    0,   0, 1, 0, 0, 0, 0},
    '{ACT_SCROLL_DOWN,  0,   0,    0,    0,  63, 1, 0, 0, 0, 0},
    '{ACT_CLEAR,        0,   0,    0,    0,   0, 1, 0, 0, 0, 0},
    '{ACT_UNUSED_HI,    0,   0,    0,    0,   0, 0, 0, 0, 0, 0}
  };

  screen_phase_t screen_phases [7] = '{
    '{64,  32, 255, 60},
    '{1,    1,   0, 30},
    '{0,    0,  85, 30},
    '{127, 63, 170, 40},
    '{8,    4,   3, 80},
    '{13,   7, 128, 80},
    '{5,    3,  15, 80}
  };

  function automatic int active_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return int'(cols_reg);
  endfunction

  function automatic int active_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return int'(rows_reg);
  endfunction

  function automatic bit on_screen(int c, int r);
    return c >= 0 && c < active_cols() && r >= 0 && r < active_rows();
  endfunction

  function automatic int clamp_to(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void wipe_screen();
    for (int i = 0; i < CELLS; i++) begin
      shadow_chr[i] = SPACE_CHAR;
      shadow_clr[i] = color_reg;
    end
    cur_c = 0;
    cur_r = 0;
  endfunction

  function automatic void blank_row(int r);
    for (int c = 0; c < active_cols(); c++) begin
      shadow_chr[r * MAX_COLS + c] = SPACE_CHAR;
      shadow_clr[r * MAX_COLS + c] = color_reg;
    end
  endfunction

  function automatic void copy_row(int dst, int src);
    for (int c = 0; c < active_cols(); c++) begin
      shadow_chr[dst * MAX_COLS + c] = shadow_chr[src * MAX_COLS + c];
      shadow_clr[dst * MAX_COLS + c] = shadow_clr[src * MAX_COLS + c];
    end
  endfunction

  function automatic void roll_rows(int n, bit up);
    int rows;
    rows = active_rows();
    if (n <= 0 || n >= rows) begin
      wipe_screen();
    end else if (up) begin
      for (int r = 0; r < rows - n; r++) copy_row(r, r + n);
      for (int r = rows - n; r < rows; r++) blank_row(r);
    end else begin
      for (int r = rows - 1; r >= n; r--) copy_row(r, r - n);
      for (int r = 0; r < n; r++) blank_row(r);
    end
  endfunction

  function automatic void advance_line();
    cur_r++;
    if (cur_r >= active_rows()) begin
      roll_rows(1, 1'b1);
      cur_r = active_rows() - 1;
    end
  endfunction

  function automatic void print_glyph(logic [7:0] code);
    int stop;
    if (code == CODE_LF) begin
      cur_c = 0;
      advance_line();
    end else if (code == CODE_CR) begin
      cur_c = 0;
    end else if (code == CODE_TAB) begin
      stop = (cur_c / TAB_WIDTH + 1) * TAB_WIDTH;
      cur_c = (stop < active_cols() - 1) ? stop : active_cols() - 1;
    end else begin
      // a cursor left outside a shrunk screen writes nothing but still moves
      if (on_screen(cur_c, cur_r)) begin
        shadow_chr[cur_r * MAX_COLS + cur_c] = code;
        shadow_clr[cur_r * MAX_COLS + cur_c] = color_reg;
      end
      cur_c++;
      if (cur_c >= active_cols()) begin
        cur_c = 0;
        advance_line();
      end
    end
  endfunction

  function automatic cell_report_t step_console(console_item_t it);
    cell_report_t rep;
    int c;
    int r;
    c = it.col;
    r = it.row;
    rep.chr = '0;
    rep.clr = '0;
    case (it.act)
      ACT_PRINT: print_glyph(it.code);
      ACT_SET_CURSOR: begin
        cur_c = clamp_to(c, active_cols() - 1);
        cur_r = clamp_to(r, active_rows() - 1);
      end
      ACT_MOVE_CURSOR: begin
        cur_c = clamp_to(cur_c + c, active_cols() - 1);
        cur_r = clamp_to(cur_r + r, active_rows() - 1);
      end
      ACT_WRITE_CHAR: if (on_screen(c, r)) shadow_chr[r * MAX_COLS + c] = it.code;
      ACT_WRITE_COLOR: if (on_screen(c, r)) shadow_clr[r * MAX_COLS + c] = it.color;
      ACT_READ_CELL: begin
        if (on_screen(c, r)) begin
          rep.chr = shadow_chr[r * MAX_COLS + c];
          rep.clr = shadow_clr[r * MAX_COLS + c];
        end else begin
          rep.chr = SPACE_CHAR;
          rep.clr = OOR_COLOR;
        end
      end
      ACT_CLEAR: wipe_screen();
      ACT_SCROLL_UP: roll_rows(int'(it.lines), 1'b1);
      ACT_SCROLL_DOWN: roll_rows(int'(it.lines), 1'b0);
      default: ;
    endcase
    rep.ccol = 6'(cur_c);
    rep.crow = 5'(cur_r);
    return rep;
  endfunction

  // mostly a cell on the screen, sometimes anything the byte holds
  function automatic logic [7:0] pick_coord(int limit);
    if ($urandom_range(99) < 80) return 8'($urandom_range(limit - 1));
    return 8'($urandom);
  endfunction

  function automatic console_item_t random_console_item(bit cheap);
    console_item_t it;
    int pick;
    it.act = ACT_PRINT;
    it.code = 8'($urandom);
    it.col = 8'($urandom);
    it.row = 8'($urandom);
    it.color = 8'($urandom);
    it.lines = 6'($urandom);
    pick = cheap ? $urandom_range(88) : $urandom_range(99);
    if (pick < 38) begin
      case ($urandom_range(9))
        0: it.code = CODE_LF;
        1: it.code = CODE_CR;
        2: it.code = CODE_TAB;
        default: ;
      endcase
    end else if (pick < 48) begin
      it.act = ACT_SET_CURSOR;
      it.col = pick_coord(active_cols());
      it.row = pick_coord(active_rows());
    end else if (pick < 56) begin
      it.act = ACT_MOVE_CURSOR;
      if ($urandom_range(99) < 80) begin
        it.col = 8'(int'($urandom_range(6)) - 3);
        it.row = 8'(int'($urandom_range(6)) - 3);
      end
    end else if (pick < 64) begin
      it.act = ACT_WRITE_CHAR;
      it.col = pick_coord(active_cols());
      it.row = pick_coord(active_rows());
    end else if (pick < 72) begin
      it.act = ACT_WRITE_COLOR;
      it.col = pick_coord(active_cols());
      it.row = pick_coord(active_rows());
    end else if (pick < 86) begin
      it.act = ACT_READ_CELL;
      it.col = pick_coord(active_cols());
      it.row = pick_coord(active_rows());
    end else if (pick < 89) begin
      it.act = 4'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
    end else if (pick < 91) begin
      it.act = ACT_CLEAR;
    end else begin
      it.act = (pick < 96) ? ACT_SCROLL_UP : ACT_SCROLL_DOWN;
      if ($urandom_range(99) < 75) it.lines = 6'($urandom_range(active_rows()));
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < 40) begin
      $display("mismatch on %s at result %0d: got %0d, want %0d", what, reports_seen, got, want);
    end
    mismatch_count++;
  endtask

  task automatic offer_item(console_item_t it, bit typed, cell_report_t golden);
    cell_report_t predicted;
    while (!steady && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.act;
    s_tdata <= {2'b00, it.lines, it.color, it.row, it.col, it.code};
    do @(posedge clk); while (!s_tready);
    predicted = step_console(it);
    awaited_cell_reports.push_back(typed ? golden : predicted);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_COLUMNS: cols_reg = value[6:0];
      REG_ROWS: rows_reg = value[5:0];
      default: color_reg = value;
    endcase
  endtask

  task automatic program_screen(screen_phase_t ph);
    s_tvalid <= 1'b0;
    while (awaited_cell_reports.size() != 0) @(posedge clk);
    // extra margin before the screen registers change
    repeat (SWEEP_DRAIN) @(posedge clk);
    write_reg(REG_COLUMNS, ph.cols);
    write_reg(REG_ROWS, ph.rows);
    write_reg(REG_COLOR, ph.color);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin : result_watch
    cell_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_cell_reports.size() == 0) begin
        report_mismatch("unexpected item", int'(m_tdata), 0);
      end else begin
        want = awaited_cell_reports.pop_front();
        if (m_tdata[7:0] !== want.chr) report_mismatch("char_out", m_tdata[7:0], want.chr);
        if (m_tdata[15:8] !== want.clr) report_mismatch("color_out", m_tdata[15:8], want.clr);
        if (m_tdata[21:16] !== want.ccol)
          report_mismatch("cursor_col", m_tdata[21:16], want.ccol);
        if (m_tdata[26:22] !== want.crow)
          report_mismatch("cursor_row", m_tdata[26:22], want.crow);
      end
      reports_seen++;
    end
  end

  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 11);
      end
    end
  end

  initial begin : stimulus
    console_item_t it;
    cell_report_t golden;
    cell_report_t blank;
    blank = '{0, 0, 0, 0};
    cols_reg = COLS_RESET;
    rows_reg = ROWS_RESET;
    color_reg = COLOR_RESET;
    wipe_screen();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      it.act = directed_rows[i].act;
      it.code = directed_rows[i].code;
      it.col = directed_rows[i].col[7:0];
      it.row = directed_rows[i].row[7:0];
      it.color = directed_rows[i].color;
      it.lines = directed_rows[i].lines;
      golden.chr = directed_rows[i].g_chr;
      golden.clr = directed_rows[i].g_clr;
      golden.ccol = 6'(directed_rows[i].g_col);
      golden.crow = 5'(directed_rows[i].g_row);
      offer_item(it, directed_rows[i].typed, golden);
    end

    foreach (screen_phases[p]) begin
      program_screen(screen_phases[p]);
      steady = (p == STEADY_PHASE);
      for (int n = 0; n < screen_phases[p].items; n++) begin
        // receiver holds off while the sender keeps the input full
        if (p == STRESS_PHASE && n == 0) hold_off_req = 1'b1;
        it = random_console_item(p == STRESS_PHASE && n < STRESS_ITEMS);
        offer_item(it, 1'b0, blank);
      end
    end
    s_tvalid <= 1'b0;
    steady = 1'b0;

    while (awaited_cell_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
